>>> src/scca_pkg.sv
// size-class chunk allocator: shared widths, codes, chunk geometry and command struct
// depends on nothing; imported by the channel interfaces and every module of the block

package scca_pkg;

   // pool geometry
   localparam int CHUNK_COUNT   = 16;
   localparam int GRANULE_BYTES = 8;
   localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);
   localparam int POOL_BYTES    = GRANULE_BYTES * CHUNK_COUNT * (CHUNK_COUNT + 1) / 2;
   localparam int MAX_REQUEST   = GRANULE_BYTES * CHUNK_COUNT;

   // field widths
   localparam int BYTES_W  = 8;
   localparam int OFFSET_W = 11;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = $clog2(CHUNK_COUNT);
   localparam int COUNT_W  = $clog2(CHUNK_COUNT + 1);
   localparam int PCT_W    = 7;

   // usage percent: used * 100 / POOL_BYTES through a reciprocal multiply
   localparam int PCT_SCALE    = 100;
   localparam int SCALED_W     = $clog2(POOL_BYTES * PCT_SCALE + 1);
   localparam int RECIP_SHIFT  = 20;
   localparam int RECIP_MULT   = (1 << RECIP_SHIFT) / POOL_BYTES;

   typedef logic [BYTES_W-1:0]     bytes_type;
   typedef logic [OFFSET_W-1:0]    offset_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [PCT_W-1:0]       pct_type;
   typedef logic [SCALED_W-1:0]    scaled_type;
   typedef logic [CHUNK_COUNT-1:0] chunk_map_type;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_NO_CHUNK   = 2'd1;
   localparam status_type STATUS_BAD_OFFSET = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic scale;
      logic estimate;
      logic publish;
   } scca_cmd_type;

   // first byte of chunk idx
   function automatic offset_type chunk_start(input int idx);
      return OFFSET_W'(GRANULE_BYTES * idx * (idx + 1) / 2);
   endfunction

   // size of chunk idx in bytes
   function automatic offset_type chunk_bytes(input index_type idx);
      return OFFSET_W'((32'(idx) + 32'd1) * GRANULE_BYTES);
   endfunction

endpackage

>>> src/scca_channels_if.sv
// size-class chunk allocator: request and response channel interfaces
// depends on scca_pkg for the payload types

interface scca_req_if import scca_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   bytes_type  request_bytes;
   offset_type release_offset;

   modport source (output valid, output kind, output request_bytes, output release_offset,
                   input ready);
   modport sink   (input valid, input kind, input request_bytes, input release_offset,
                   output ready);
endinterface

interface scca_rsp_if import scca_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   offset_type granted_offset;
   index_type  granted_index;
   offset_type used_bytes;
   count_type  used_chunks;
   pct_type    usage_percent;

   modport source (output valid, output status, output granted_offset, output granted_index,
                   output used_bytes, output used_chunks, output usage_percent,
                   input ready);
   modport sink   (input valid, input status, input granted_offset, input granted_index,
                   input used_bytes, input used_chunks, input usage_percent,
                   output ready);
endinterface

>>> src/scca_datapath.sv
// size-class chunk allocator datapath: chunk map, first-fit search, offset match,
// running usage counters, percent calculation and response register; uses scca_pkg

module scca_datapath import scca_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  scca_cmd_type cmd,
   input  logic         in_kind,
   input  bytes_type    in_request_bytes,
   input  offset_type   in_release_offset,
   output status_type   out_status,
   output offset_type   out_granted_offset,
   output index_type    out_granted_index,
   output offset_type   out_used_bytes,
   output count_type    out_used_chunks,
   output pct_type      out_usage_percent
);

   logic          kind_ff;
   bytes_type     nbytes_ff;
   offset_type    offset_ff;
   chunk_map_type in_use_ff, in_use_in;
   offset_type    used_bytes_ff, used_bytes_in;
   count_type     used_chunks_ff, used_chunks_in;
   status_type    status_ff, status_in;
   offset_type    goff_ff, goff_in;
   index_type     gidx_ff, gidx_in;
   scaled_type    scaled_ff, scaled_in;
   pct_type       quot_ff, quot_in;
   pct_type       pct_fixed;
   status_type    out_status_ff;
   offset_type    out_goff_ff;
   index_type     out_gidx_ff;
   offset_type    out_used_bytes_ff;
   count_type     out_used_chunks_ff;
   pct_type       out_pct_ff;

   bytes_type     size_class;
   logic          size_ok;
   logic          alloc_found;
   index_type     alloc_idx;
   offset_type    alloc_off;
   logic          free_found;
   index_type     free_idx;
   logic [31:0]   recip_prod;
   logic [31:0]   remainder;

   // request capture on the input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= in_kind;
         nbytes_ff <= in_request_bytes;
         offset_ff <= in_release_offset;
      end
   end

   // smallest fitting class and size range check
   assign size_class = (nbytes_ff - 1'b1) >> GRANULE_SHIFT;
   assign size_ok    = (nbytes_ff != '0) && (32'(nbytes_ff) <= MAX_REQUEST);

   // first free chunk from the class upward, lowest index wins
   always_comb begin
      alloc_found = 1'b0;
      alloc_idx   = '0;
      alloc_off   = '0;
      for (int i = CHUNK_COUNT - 1; i >= 0; i--) begin
         if (!in_use_ff[i] && (32'(size_class) <= i)) begin
            alloc_found = 1'b1;
            alloc_idx   = INDEX_W'(i);
            alloc_off   = chunk_start(i);
         end
      end
   end

   // chunk whose start equals the release offset
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CHUNK_COUNT - 1; i >= 0; i--) begin
         if (offset_ff == chunk_start(i)) begin
            free_found = 1'b1;
            free_idx   = INDEX_W'(i);
         end
      end
   end

   // map and counter update for the request
   always_comb begin
      in_use_in      = in_use_ff;
      used_bytes_in  = used_bytes_ff;
      used_chunks_in = used_chunks_ff;
      status_in      = STATUS_OK;
      goff_in        = '0;
      gidx_in        = '0;
      if (kind_ff == KIND_ALLOC) begin
         if (size_ok && alloc_found) begin
            in_use_in[alloc_idx] = 1'b1;
            used_bytes_in        = used_bytes_ff + chunk_bytes(alloc_idx);
            used_chunks_in       = used_chunks_ff + 1'b1;
            goff_in              = alloc_off;
            gidx_in              = alloc_idx;
         end else begin
            status_in = STATUS_NO_CHUNK;
         end
      end else begin
         if (free_found) begin
            gidx_in = free_idx;
            // freeing a chunk that is already free changes nothing
            if (in_use_ff[free_idx]) begin
               in_use_in[free_idx] = 1'b0;
               used_bytes_in       = used_bytes_ff - chunk_bytes(free_idx);
               used_chunks_in      = used_chunks_ff - 1'b1;
            end
         end else begin
            status_in = STATUS_BAD_OFFSET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff      <= '0;
         used_bytes_ff  <= '0;
         used_chunks_ff <= '0;
      end else if (cmd.exec) begin
         in_use_ff      <= in_use_in;
         used_bytes_ff  <= used_bytes_in;
         used_chunks_ff <= used_chunks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         goff_ff   <= goff_in;
         gidx_ff   <= gidx_in;
      end
   end

   // percent: scale by 100, reciprocal estimate, then one correction step
   assign scaled_in  = SCALED_W'(32'(used_bytes_ff) * PCT_SCALE);
   assign recip_prod = 32'(scaled_ff) * 32'(RECIP_MULT);
   assign quot_in    = PCT_W'(recip_prod >> RECIP_SHIFT);
   assign remainder  = 32'(scaled_ff) - 32'(quot_ff) * 32'(POOL_BYTES);
   assign pct_fixed  = (remainder >= 32'(POOL_BYTES)) ? quot_ff + 1'b1 : quot_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.estimate) begin
         quot_ff <= quot_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_status_ff      <= status_ff;
         out_goff_ff        <= goff_ff;
         out_gidx_ff        <= gidx_ff;
         out_used_bytes_ff  <= used_bytes_ff;
         out_used_chunks_ff <= used_chunks_ff;
         out_pct_ff         <= pct_fixed;
      end
   end

   assign out_status         = out_status_ff;
   assign out_granted_offset = out_goff_ff;
   assign out_granted_index  = out_gidx_ff;
   assign out_used_bytes     = out_used_bytes_ff;
   assign out_used_chunks    = out_used_chunks_ff;
   assign out_usage_percent  = out_pct_ff;

   // chunk counter tracks the map
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      32'(used_chunks_ff) == $countones(in_use_ff))
      else $error("chunk counter out of step with chunk map");

   // a grant always lands on a chunk that was free
   a_grant_was_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == KIND_ALLOC && status_in == STATUS_OK) |->
         !in_use_ff[alloc_idx] && in_use_in[alloc_idx])
      else $error("allocate granted a chunk already in use");

   // published percent never above a full pool
   a_pct_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (32'(out_pct_ff) <= PCT_SCALE))
      else $error("usage percent above full pool");

endmodule

>>> src/scca_controller.sv
// size-class chunk allocator controller: sequences one request through the datapath
// and owns the response valid flag; uses scca_pkg for the command struct

module scca_controller import scca_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output scca_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_EST   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       publish;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // result may go out when the response register is empty or draining
   assign publish   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  state_in = S_SCALE;
         S_SCALE: state_in = S_EST;
         S_EST:   state_in = S_DONE;
         S_DONE:  if (publish) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cmd.load     = accept;
   assign cmd.exec     = (state_ff == S_EXEC);
   assign cmd.scale    = (state_ff == S_SCALE);
   assign cmd.estimate = (state_ff == S_EST);
   assign cmd.publish  = publish;

   // a response appears only out of the final step
   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response valid raised outside the final step");

   // an accepted request starts execution next cycle
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not start");

   // a finished result waits while the response register is full and stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("result overwrote a stalled response");

endmodule

>>> src/size_class_chunk_allocator.sv
// size-class chunk allocator top level: joins controller and datapath to the channels
// depends on scca_pkg, scca_req_if, scca_rsp_if, scca_controller and scca_datapath
//
// A pool of 1088 bytes is split into 16 chunks; chunk i holds 8*(i+1) bytes and
// starts at offset 8*i*(i+1)/2. Requests come in on req_chan (valid/ready): kind 0
// allocates request_bytes by first fit from the smallest fitting class upward, kind 1
// frees the chunk that starts at release_offset. Every request gives exactly one
// response on rsp_chan with status, granted offset and index, and the pool usage
// (bytes, chunks, percent) after the request.
// After the request transfer the sequencer steps through update, scale, reciprocal
// estimate and correction, and the result is published into the response register
// once that register is free or draining. One request is in progress at a time, so
// the block takes no new request until the current result has been published.
// The response register lets the next request be taken while a result waits; if
// the receiver stalls, the following result holds in the datapath until the
// register drains, and no further request is taken until then.
// Synchronous reset marks every chunk free, clears the usage counters and empties
// the response register.

module size_class_chunk_allocator import scca_pkg::*; (
   input logic      clock,
   input logic      reset,
   scca_req_if.sink   req_chan,
   scca_rsp_if.source rsp_chan
);

   scca_cmd_type cmd;

   // sequencing
   scca_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // chunk map, search and usage
   scca_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .in_kind            (req_chan.kind),
      .in_request_bytes   (req_chan.request_bytes),
      .in_release_offset  (req_chan.release_offset),
      .out_status         (rsp_chan.status),
      .out_granted_offset (rsp_chan.granted_offset),
      .out_granted_index  (rsp_chan.granted_index),
      .out_used_bytes     (rsp_chan.used_bytes),
      .out_used_chunks    (rsp_chan.used_chunks),
      .out_usage_percent  (rsp_chan.usage_percent)
   );

endmodule
